### rtl/msrc_pkg.sv
// Shared types, codes and the CRC-16 byte step for the Modbus sensor reply checker.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package msrc_pkg;

    localparam int unsigned FrameBytes = 9;
    localparam int unsigned CrcBytes   = 7;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] TEMP_LIMIT_RESET = 16'd2000;
    localparam logic signed [16:0] HUM_INVALID = 17'h1FFFF;

    localparam logic [3:0] BYTE_HUM_HI = 4'd3;
    localparam logic [3:0] BYTE_HUM_LO = 4'd4;
    localparam logic [3:0] BYTE_TMP_HI = 4'd5;
    localparam logic [3:0] BYTE_TMP_LO = 4'd6;
    localparam logic [3:0] BYTE_CRC_LO = 4'd7;
    localparam logic [3:0] BYTE_CRC_HI = 4'd8;
    localparam logic [3:0] BYTE_FULL   = 4'(FrameBytes);
    localparam logic [3:0] BYTE_CRC_END = 4'(CrcBytes);

    typedef enum logic {
        MODE_BYTE = 1'b0,
        MODE_END  = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_VALID       = 2'd0,
        STATUS_CRC_ERROR   = 2'd1,
        STATUS_NO_RESPONSE = 2'd2
    } status_t;

    typedef struct packed {
        logic [3:0]  count;
        logic [15:0] crc;
        logic [15:0] hum;
        logic [15:0] temp;
        logic [15:0] rx_crc;
    } frame_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### rtl/msrc_in_if.sv
// Input channel: reply bytes and end-of-reception marks with valid/ready.
// Depends on msrc_pkg for the mode code type.
interface msrc_in_if;
    logic             valid;
    logic             ready;
    msrc_pkg::mode_t  mode;
    logic [7:0]       rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

### rtl/msrc_out_if.sv
// Result channel: status, humidity and temperature with valid/ready.
// Depends on msrc_pkg for the status code type.
interface msrc_out_if;
    logic               valid;
    logic               ready;
    msrc_pkg::status_t  status;
    logic signed [16:0] humidity;
    logic [15:0]        temperature;

    modport source (output valid, output status, output humidity, output temperature,
                    input ready);
    modport sink   (input valid, input status, input humidity, input temperature,
                    output ready);
endinterface

### rtl/msrc_frame.sv
// Frame collector: byte counter, running CRC-16 and field captures of one reply.
// Depends on msrc_pkg (frame_t, crc_step, byte positions).
module msrc_frame (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_fire,
    input  logic             end_fire,
    input  logic [7:0]       rx_byte,
    output msrc_pkg::frame_t frame
);

    msrc_pkg::frame_t frame_reg;
    msrc_pkg::frame_t frame_next;

    always_comb
    begin
        frame_next = frame_reg;
        if (end_fire)
        begin
            frame_next.count  = 4'd0;
            frame_next.crc    = msrc_pkg::CRC_INIT;
            frame_next.hum    = 16'd0;
            frame_next.temp   = 16'd0;
            frame_next.rx_crc = 16'd0;
        end
        else if (byte_fire && (frame_reg.count < msrc_pkg::BYTE_FULL))
        begin
            if (frame_reg.count < msrc_pkg::BYTE_CRC_END)
                frame_next.crc = msrc_pkg::crc_step(frame_reg.crc, rx_byte);
            unique case (frame_reg.count)
                msrc_pkg::BYTE_HUM_HI: frame_next.hum[15:8]   = rx_byte;
                msrc_pkg::BYTE_HUM_LO: frame_next.hum[7:0]    = rx_byte;
                msrc_pkg::BYTE_TMP_HI: frame_next.temp[15:8]  = rx_byte;
                msrc_pkg::BYTE_TMP_LO: frame_next.temp[7:0]   = rx_byte;
                msrc_pkg::BYTE_CRC_LO: frame_next.rx_crc[7:0] = rx_byte;
                msrc_pkg::BYTE_CRC_HI: frame_next.rx_crc[15:8] = rx_byte;
                default: ;
            endcase
            frame_next.count = frame_reg.count + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg.count  <= 4'd0;
            frame_reg.crc    <= msrc_pkg::CRC_INIT;
            frame_reg.hum    <= 16'd0;
            frame_reg.temp   <= 16'd0;
            frame_reg.rx_crc <= 16'd0;
        end
        else
        begin
            frame_reg <= frame_next;
        end
    end

    assign frame = frame_reg;

endmodule

### rtl/msrc_result.sv
// Reply evaluation and result register: CRC check, temperature clamp, last good value.
// Depends on msrc_pkg (frame_t, status codes) and msrc_out_if.
module msrc_result (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             end_fire,
    input  msrc_pkg::frame_t frame,
    input  logic [15:0]      temp_limit,
    msrc_out_if.source       result
);

    logic               valid_reg;
    logic               valid_next;
    msrc_pkg::status_t  status_reg;
    msrc_pkg::status_t  status_next;
    logic signed [16:0] hum_reg;
    logic signed [16:0] hum_next;
    logic [15:0]        temp_reg;
    logic [15:0]        temp_next;
    logic [15:0]        last_temp_reg;
    logic [15:0]        last_temp_next;
    logic [15:0]        clamped;

    assign clamped = (frame.temp > temp_limit) ? 16'd0 : frame.temp;

    always_comb
    begin
        last_temp_next = last_temp_reg;
        status_next    = msrc_pkg::STATUS_CRC_ERROR;
        hum_next       = msrc_pkg::HUM_INVALID;
        temp_next      = last_temp_reg;
        if (frame.count == 4'd0)
        begin
            status_next = msrc_pkg::STATUS_NO_RESPONSE;
        end
        else if ((frame.count == msrc_pkg::BYTE_FULL) && (frame.crc == frame.rx_crc))
        begin
            status_next = msrc_pkg::STATUS_VALID;
            hum_next    = {1'b0, frame.hum};
            temp_next   = clamped;
            if (end_fire)
                last_temp_next = clamped;
        end
        valid_next = end_fire || (valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            last_temp_reg <= 16'd0;
        end
        else
        begin
            valid_reg     <= valid_next;
            last_temp_reg <= last_temp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_fire)
        begin
            status_reg <= status_next;
            hum_reg    <= hum_next;
            temp_reg   <= temp_next;
        end
    end

    assign result.valid       = valid_reg;
    assign result.status      = status_reg;
    assign result.humidity    = hum_reg;
    assign result.temperature = temp_reg;

endmodule

### rtl/modbus_sensor_reply_checker.sv
// Top level of the Modbus RTU sensor reply checker: handshake, limit register, submodules.
// Depends on msrc_pkg, msrc_in_if, msrc_out_if, msrc_frame and msrc_result.
//
// Usage: reply carries one transfer per received byte (mode byte) and one transfer
// marking end of reception (mode end). Each end transfer yields exactly one transfer
// on result with status, humidity and temperature; byte transfers yield none.
// The result is registered and appears in the cycle after the end transfer is accepted.
// Throughput: one transfer per cycle while reply.ready is high; the CRC-16 byte step
// and the field captures complete in the cycle the byte is accepted.
// The result register holds one result; reply.ready is low only while that result
// waits and result.ready is low, so a stalled receiver stalls the sender of reply.
// Bytes past the ninth are dropped; replies of 1-8 bytes: CRC error; empty: no response.
// Reset: frame state clears, CRC restarts at 0xFFFF, the last good temperature is 0,
// temp_limit returns to 2000 and no result is pending.
// cfg_we/cfg_wdata write temp_limit; write it only while no reply is in progress.
module modbus_sensor_reply_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    msrc_in_if.sink     reply,
    msrc_out_if.source  result
);

    logic [15:0]      limit_reg;
    logic             fire;
    logic             byte_fire;
    logic             end_fire;
    msrc_pkg::frame_t frame;

    assign reply.ready = !result.valid || result.ready;
    assign fire        = reply.valid && reply.ready;
    assign byte_fire   = fire && (reply.mode == msrc_pkg::MODE_BYTE);
    assign end_fire    = fire && (reply.mode == msrc_pkg::MODE_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= msrc_pkg::TEMP_LIMIT_RESET;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
        end
    end

    msrc_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (byte_fire),
        .end_fire  (end_fire),
        .rx_byte   (reply.rx_byte),
        .frame     (frame)
    );

    msrc_result u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .end_fire   (end_fire),
        .frame      (frame),
        .temp_limit (limit_reg),
        .result     (result)
    );

endmodule
